[hw/rtl/srp_pkg.sv]
// shared types and constants of the sensor response parser
`timescale 1ns / 1ps

package srp_pkg;

    // input request: one byte of a response frame
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } t_in_req;

    // output request: one parsed record
    typedef struct packed {
        logic [2:0]  rec_kind;
        logic [1:0]  error_code;
        logic [7:0]  resp_seq;
        logic [7:0]  cmd_code;
        logic [7:0]  ret_code;
        logic [7:0]  ctrl_state;
        logic [7:0]  block_index;
        logic [7:0]  sensor_index;
        logic [15:0] sensor_ident;
        logic [15:0] reading;
        logic [31:0] update_count;
        logic [31:0] energy_accum;
    } t_out_rec;

    // record kinds
    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_TEMP   = 3'd1;
    localparam logic [2:0] KIND_FREQ   = 3'd2;
    localparam logic [2:0] KIND_POWR   = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_EYE      = 2'd1;
    localparam logic [1:0] ERR_BAD_TYPE = 2'd2;

    // block type codes held while reading sensors
    localparam logic [1:0] BTYPE_NONE = 2'd0;
    localparam logic [1:0] BTYPE_TEMP = 2'd1;
    localparam logic [1:0] BTYPE_FREQ = 2'd2;
    localparam logic [1:0] BTYPE_POWR = 2'd3;

    // four-character block type tags
    localparam logic [31:0] TAG_TEMP = 32'h54454D50;
    localparam logic [31:0] TAG_FREQ = 32'h46524551;
    localparam logic [31:0] TAG_POWR = 32'h504F5752;

    // frame layout
    localparam logic [7:0] HDR_LAST     = 8'd44;
    localparam logic [7:0] OFS_SEQ      = 8'd0;
    localparam logic [7:0] OFS_CMD      = 8'd1;
    localparam logic [7:0] OFS_STATUS   = 8'd2;
    localparam logic [7:0] OFS_STATE    = 8'd9;
    localparam logic [7:0] OFS_EYE_LO   = 8'd37;
    localparam logic [7:0] OFS_EYE_HI   = 8'd42;
    localparam logic [7:0] OFS_NBLOCKS  = 8'd43;
    localparam logic [7:0] BLKHDR_LAST  = 8'd7;
    localparam logic [7:0] SMALL_SIZE   = 8'd4;
    localparam logic [7:0] POWR_SIZE    = 8'd12;
    localparam logic [7:0] SMALL_LAST   = 8'd3;
    localparam logic [7:0] POWR_TAG_END = 8'd5;
    localparam logic [7:0] POWR_LAST    = 8'd11;

    // eye catcher text, one character per position
    function automatic logic [7:0] eye_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0: ch = 8'h53;   // S
            3'd1: ch = 8'h45;   // E
            3'd2: ch = 8'h4E;   // N
            3'd3: ch = 8'h53;   // S
            3'd4: ch = 8'h4F;   // O
            3'd5: ch = 8'h52;   // R
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[hw/rtl/srp_parser.sv]
// parse state registers and per-byte record decode
`timescale 1ns / 1ps

module srp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  srp_pkg::t_in_req  i_req,
    output logic              o_rec_valid,
    output srp_pkg::t_out_rec o_rec
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_BLKHDR = 3'd2;
    localparam logic [2:0] PH_SENSOR = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    logic [2:0]  r_phase,        n_phase;
    logic [7:0]  r_byte_offset,  n_byte_offset;
    logic [7:0]  r_blocks_total, n_blocks_total;
    logic [7:0]  r_block_count,  n_block_count;
    logic [7:0]  r_sensors_in,   n_sensors_in;
    logic [7:0]  r_sensor_count, n_sensor_count;
    logic [7:0]  r_stride,       n_stride;
    logic [1:0]  r_block_type,   n_block_type;
    logic [63:0] r_field_shift,  n_field_shift;
    logic [31:0] r_tag_hold,     n_tag_hold;
    logic [31:0] r_header_regs,  n_header_regs;
    logic        r_eye_ok,       n_eye_ok;

    // decode of one byte against the current parse state
    always_comb begin
        logic [2:0]  cur_phase;
        logic [7:0]  o;
        logic [7:0]  b;
        logic [7:0]  cur_bc;
        logic [7:0]  bc_inc;
        logic [7:0]  sc_inc;
        logic [7:0]  len;
        logic [8:0]  o_inc;
        logic [63:0] cur_fs;
        logic [63:0] fs_new;
        logic [31:0] tag;
        logic        eye_match;
        logic        active;

        b         = i_req.data_byte;
        cur_phase = i_req.first_byte ? PH_HEADER : r_phase;
        o         = i_req.first_byte ? 8'd0 : r_byte_offset;
        cur_bc    = i_req.first_byte ? 8'd0 : r_block_count;
        cur_fs    = i_req.first_byte ? 64'd0 : r_field_shift;
        bc_inc    = cur_bc + 8'd1;
        sc_inc    = r_sensor_count + 8'd1;
        o_inc     = {1'b0, o} + 9'd1;
        fs_new    = {cur_fs[55:0], b};
        tag       = fs_new[63:32];
        len       = fs_new[15:8];
        eye_match = (b == srp_pkg::eye_char(3'(o - srp_pkg::OFS_EYE_LO)));
        active    = (cur_phase == PH_HEADER) || (cur_phase == PH_BLKHDR) ||
                    (cur_phase == PH_SENSOR);

        // a first byte clears all progress
        if (i_req.first_byte) begin
            n_phase        = PH_HEADER;
            n_byte_offset  = 8'd0;
            n_blocks_total = 8'd0;
            n_block_count  = 8'd0;
            n_sensors_in   = 8'd0;
            n_sensor_count = 8'd0;
            n_stride       = 8'd0;
            n_block_type   = srp_pkg::BTYPE_NONE;
            n_field_shift  = 64'd0;
            n_tag_hold     = 32'd0;
            n_header_regs  = 32'd0;
            n_eye_ok       = 1'b0;
        end else begin
            n_phase        = r_phase;
            n_byte_offset  = r_byte_offset;
            n_blocks_total = r_blocks_total;
            n_block_count  = r_block_count;
            n_sensors_in   = r_sensors_in;
            n_sensor_count = r_sensor_count;
            n_stride       = r_stride;
            n_block_type   = r_block_type;
            n_field_shift  = r_field_shift;
            n_tag_hold     = r_tag_hold;
            n_header_regs  = r_header_regs;
            n_eye_ok       = r_eye_ok;
        end

        o_rec_valid        = 1'b0;
        o_rec              = '0;
        o_rec.rec_kind     = srp_pkg::KIND_HEADER;
        o_rec.error_code   = srp_pkg::ERR_NONE;

        if (active) begin
            case (cur_phase)
                // fixed header fields, eye catcher and block count
                PH_HEADER: begin
                    if (o == srp_pkg::OFS_SEQ)    n_header_regs[31:24] = b;
                    if (o == srp_pkg::OFS_CMD)    n_header_regs[23:16] = b;
                    if (o == srp_pkg::OFS_STATUS) n_header_regs[15:8]  = b;
                    if (o == srp_pkg::OFS_STATE)  n_header_regs[7:0]   = b;
                    if (o >= srp_pkg::OFS_EYE_LO && o <= srp_pkg::OFS_EYE_HI) begin
                        n_eye_ok = (o == srp_pkg::OFS_EYE_LO) ? eye_match
                                                              : (n_eye_ok && eye_match);
                    end
                    if (o == srp_pkg::OFS_NBLOCKS) n_blocks_total = b;
                    if (o == srp_pkg::HDR_LAST) begin
                        o_rec_valid = 1'b1;
                        if (!n_eye_ok) begin
                            o_rec.rec_kind   = srp_pkg::KIND_ERROR;
                            o_rec.error_code = srp_pkg::ERR_EYE;
                            n_phase          = PH_DONE;
                        end else begin
                            n_block_count = 8'd0;
                            n_byte_offset = 8'd0;
                            n_field_shift = 64'd0;
                            n_phase = (n_blocks_total == 8'd0) ? PH_DONE : PH_BLKHDR;
                        end
                    end else begin
                        n_byte_offset = o_inc[7:0];
                    end
                end

                // eight-byte block header: type, reserved, format, length, count
                PH_BLKHDR: begin
                    n_field_shift = fs_new;
                    if (o < srp_pkg::BLKHDR_LAST) begin
                        n_byte_offset = o_inc[7:0];
                    end else if (tag != srp_pkg::TAG_TEMP && tag != srp_pkg::TAG_FREQ &&
                                 tag != srp_pkg::TAG_POWR) begin
                        o_rec_valid       = 1'b1;
                        o_rec.rec_kind    = srp_pkg::KIND_ERROR;
                        o_rec.error_code  = srp_pkg::ERR_BAD_TYPE;
                        o_rec.block_index = cur_bc;
                        n_phase           = PH_DONE;
                    end else begin
                        if (tag == srp_pkg::TAG_POWR) begin
                            n_block_type = srp_pkg::BTYPE_POWR;
                            n_stride = (len < srp_pkg::POWR_SIZE) ? srp_pkg::POWR_SIZE : len;
                        end else begin
                            n_block_type = (tag == srp_pkg::TAG_TEMP) ? srp_pkg::BTYPE_TEMP
                                                                      : srp_pkg::BTYPE_FREQ;
                            n_stride = (len < srp_pkg::SMALL_SIZE) ? srp_pkg::SMALL_SIZE : len;
                        end
                        n_sensors_in   = fs_new[7:0];
                        n_sensor_count = 8'd0;
                        n_byte_offset  = 8'd0;
                        n_field_shift  = 64'd0;
                        if (fs_new[7:0] == 8'd0) begin
                            n_block_count = bc_inc;
                            n_phase = (bc_inc >= n_blocks_total) ? PH_DONE : PH_BLKHDR;
                        end else begin
                            n_phase = PH_SENSOR;
                        end
                    end
                end

                // sensor records at the block stride
                PH_SENSOR: begin
                    if (r_block_type == srp_pkg::BTYPE_POWR) begin
                        if (o < srp_pkg::POWR_SIZE) n_field_shift = fs_new;
                        if (o == srp_pkg::POWR_TAG_END) begin
                            n_tag_hold    = fs_new[31:0];
                            n_field_shift = {48'd0, fs_new[47:32]};
                        end
                        if (o == srp_pkg::POWR_LAST) begin
                            o_rec_valid        = 1'b1;
                            o_rec.rec_kind     = srp_pkg::KIND_POWR;
                            o_rec.block_index  = cur_bc;
                            o_rec.sensor_index = r_sensor_count;
                            o_rec.sensor_ident = fs_new[63:48];
                            o_rec.reading      = fs_new[15:0];
                            o_rec.update_count = r_tag_hold;
                            o_rec.energy_accum = fs_new[47:16];
                        end
                    end else begin
                        if (o < srp_pkg::SMALL_SIZE) n_field_shift = fs_new;
                        if (o == srp_pkg::SMALL_LAST) begin
                            o_rec_valid        = 1'b1;
                            o_rec.rec_kind     = {1'b0, r_block_type};
                            o_rec.block_index  = cur_bc;
                            o_rec.sensor_index = r_sensor_count;
                            o_rec.sensor_ident = fs_new[31:16];
                            o_rec.reading      = fs_new[15:0];
                        end
                    end
                    if (o_inc >= {1'b0, r_stride}) begin
                        n_sensor_count = sc_inc;
                        n_byte_offset  = 8'd0;
                        n_field_shift  = 64'd0;
                        if (sc_inc >= r_sensors_in) begin
                            n_block_count = bc_inc;
                            n_phase = (bc_inc >= r_blocks_total) ? PH_DONE : PH_BLKHDR;
                        end
                    end else begin
                        n_byte_offset = o_inc[7:0];
                    end
                end

                default: begin
                    n_phase = cur_phase;
                end
            endcase
        end

        o_rec.resp_seq   = n_header_regs[31:24];
        o_rec.cmd_code   = n_header_regs[23:16];
        o_rec.ret_code   = n_header_regs[15:8];
        o_rec.ctrl_state = n_header_regs[7:0];
    end

    // parse state update on each consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_byte_offset  <= 8'd0;
            r_blocks_total <= 8'd0;
            r_block_count  <= 8'd0;
            r_sensors_in   <= 8'd0;
            r_sensor_count <= 8'd0;
            r_stride       <= 8'd0;
            r_block_type   <= srp_pkg::BTYPE_NONE;
            r_field_shift  <= 64'd0;
            r_tag_hold     <= 32'd0;
            r_header_regs  <= 32'd0;
            r_eye_ok       <= 1'b0;
        end else if (i_en) begin
            r_phase        <= n_phase;
            r_byte_offset  <= n_byte_offset;
            r_blocks_total <= n_blocks_total;
            r_block_count  <= n_block_count;
            r_sensors_in   <= n_sensors_in;
            r_sensor_count <= n_sensor_count;
            r_stride       <= n_stride;
            r_block_type   <= n_block_type;
            r_field_shift  <= n_field_shift;
            r_tag_hold     <= n_tag_hold;
            r_header_regs  <= n_header_regs;
            r_eye_ok       <= n_eye_ok;
        end
    end

endmodule

[hw/rtl/srp_out_stage.sv]
// result register of the sensor response parser
`timescale 1ns / 1ps

module srp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  srp_pkg::t_out_rec i_rec,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output srp_pkg::t_out_rec o_out_rec
);

    logic              r_valid, n_valid;
    srp_pkg::t_out_rec r_rec;

    // hold until taken, reload in the cycle it is taken
    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_out_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // record payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rec <= i_rec;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_rec   = r_rec;

endmodule

[hw/rtl/sensor_response_parser_core.sv]
// top level of the sensor response parser
`timescale 1ns / 1ps
// record path: the last byte is held in the byte register, then decoded into the result register
// throughput: one byte per cycle; the byte register drains into the parse
//   state and result register whenever the result register is free or taken
// reset: synchronous active low; parser idles until a first byte arrives
// bytes that cause no record are consumed the same as any other

module sensor_response_parser_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  srp_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output srp_pkg::t_out_rec o_out_rec
);

    logic              r_in_valid, n_in_valid;
    srp_pkg::t_in_req  r_in_req;
    logic              w_advance;
    logic              w_in_accept;
    logic              w_rec_valid;
    srp_pkg::t_out_rec w_rec;

    // byte register moves on when the result side has room
    assign w_advance   = r_in_valid && (!o_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_comb begin
        if (w_in_accept) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // input request payload
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_req <= i_in_req;
        end
    end

    // parse state and record decode
    srp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_advance),
        .i_req       (r_in_req),
        .o_rec_valid (w_rec_valid),
        .o_rec       (w_rec)
    );

    // result register
    srp_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_advance && w_rec_valid),
        .i_rec       (w_rec),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_rec   (o_out_rec)
    );

endmodule

[verif/sensor_response_parser_core_test.sv]
// self-checking testbench of the sensor response parser core
`timescale 1ns / 1ps

module sensor_response_parser_core_test;

    // parse position of the local response model
    typedef enum logic [2:0] {
        PRS_IDLE,
        PRS_HEADER,
        PRS_BLKHDR,
        PRS_SENSOR,
        PRS_DONE
    } t_parse_phase;

    // how a stimulus row is checked
    typedef enum logic [2:0] {
        ROW_PREDICTED,
        ROW_NOTHING,
        ROW_HEADER,
        ROW_EYE_ERR,
        ROW_TYPE_ERR
    } t_row_outcome;

    // contents of the sensor record bytes
    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } t_fill;

    typedef struct packed {
        logic [31:0] tag;
        logic [7:0]  len;
        logic [7:0]  count;
        logic [7:0]  emit;      // sensors actually sent
    } t_blk_spec;

    typedef struct packed {
        t_row_outcome     outcome;
        logic             lead_noise;   // bytes without a first byte ahead of the frame
        logic [7:0]       seq;
        logic [7:0]       cmd;
        logic [7:0]       status;
        logic [7:0]       state;
        logic [2:0]       eye_bad;      // 0 intact, else the eye character spoiled
        logic [7:0]       nblocks;      // block count written in the header
        logic [1:0]       nblk_emit;    // blocks actually sent
        t_blk_spec [0:2]  blk;
        t_fill            fill;
        logic [7:0]       cut;          // truncate the frame to this many bytes
        logic [3:0]       tail;         // trailing bytes without a first byte
    } t_frame;

    typedef struct packed {
        srp_pkg::t_in_req req;
        logic             typed;
    } t_stim_byte;

    localparam logic [47:0] EYE_TEXT = "SENSOR";
    localparam t_blk_spec   NO_BLK   = '0;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    srp_pkg::t_in_req  i_in_req;
    logic              o_out_valid;
    logic              i_out_stall;
    srp_pkg::t_out_rec o_out_rec;

    sensor_response_parser_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rec   (o_out_rec)
    );

    // response model state
    t_parse_phase prs_phase;
    logic [7:0]   ofs;
    logic [7:0]   blocks_total;
    logic [7:0]   block_idx;
    logic [7:0]   sensors_in_blk;
    logic [7:0]   sensor_idx;
    logic [7:0]   stride_len;
    logic [1:0]   btype;
    logic [63:0]  shift;
    logic [31:0]  tag_latch;
    logic [31:0]  hdr_bytes;
    logic         eye_match;

    // stimulus and expected records
    t_stim_byte        stim_q [$];
    srp_pkg::t_out_rec typed_q [$];
    srp_pkg::t_out_rec rec_q [$];
    t_stim_byte        cur;
    t_frame            directed_rows [14];

    int fail_count;
    int bytes_done;
    int total_bytes;
    int frames_built;
    int recs_checked;
    int kind_seen [5];
    int hold_left;
    bit pressure_done;

    // clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // clear all parse progress
    function automatic void clear_parse();
        prs_phase      = PRS_IDLE;
        ofs            = '0;
        blocks_total   = '0;
        block_idx      = '0;
        sensors_in_blk = '0;
        sensor_idx     = '0;
        stride_len     = '0;
        btype          = srp_pkg::BTYPE_NONE;
        shift          = '0;
        tag_latch      = '0;
        hdr_bytes      = '0;
        eye_match      = 1'b0;
    endfunction

    // record carrying the frame's header bytes
    function automatic srp_pkg::t_out_rec make_rec(
            input logic [2:0] kind, input logic [1:0] err,
            input logic [7:0] blk, input logic [7:0] sen,
            input logic [15:0] id, input logic [15:0] rd,
            input logic [31:0] upd, input logic [31:0] acc);
        srp_pkg::t_out_rec r;
        r.rec_kind     = kind;
        r.error_code   = err;
        r.resp_seq     = hdr_bytes[31:24];
        r.cmd_code     = hdr_bytes[23:16];
        r.ret_code     = hdr_bytes[15:8];
        r.ctrl_state   = hdr_bytes[7:0];
        r.block_index  = blk;
        r.sensor_index = sen;
        r.sensor_ident = id;
        r.reading      = rd;
        r.update_count = upd;
        r.energy_accum = acc;
        return r;
    endfunction

    // step to the next block or finish the frame
    function automatic void advance_block();
        block_idx = block_idx + 8'd1;
        ofs       = '0;
        shift     = '0;
        prs_phase = (block_idx >= blocks_total) ? PRS_DONE : PRS_BLKHDR;
    endfunction

    // advance the model by one accepted byte
    task automatic parse_byte(input srp_pkg::t_in_req req, output bit got,
                              output srp_pkg::t_out_rec rec);
        logic [7:0]  b;
        logic [7:0]  o;
        logic [31:0] tag;
        logic [7:0]  rsize;
        bit          known;
        b   = req.data_byte;
        got = 1'b0;
        rec = '0;
        if (req.first_byte) begin
            clear_parse();
            prs_phase = PRS_HEADER;
        end else if (prs_phase == PRS_IDLE || prs_phase == PRS_DONE) begin
            return;
        end
        o = ofs;
        case (prs_phase)
            // fixed header: capture fields, check the eye catcher
            PRS_HEADER: begin
                if (o == srp_pkg::OFS_SEQ) hdr_bytes[31:24] = b;
                if (o == srp_pkg::OFS_CMD) hdr_bytes[23:16] = b;
                if (o == srp_pkg::OFS_STATUS) hdr_bytes[15:8] = b;
                if (o == srp_pkg::OFS_STATE) hdr_bytes[7:0] = b;
                if (o >= srp_pkg::OFS_EYE_LO && o <= srp_pkg::OFS_EYE_HI) begin
                    known = (b == EYE_TEXT[8 * (srp_pkg::OFS_EYE_HI - o) +: 8]);
                    eye_match = (o == srp_pkg::OFS_EYE_LO) ? known : (eye_match && known);
                end
                if (o == srp_pkg::OFS_NBLOCKS) blocks_total = b;
                if (o == srp_pkg::HDR_LAST) begin
                    got = 1'b1;
                    if (!eye_match) begin
                        rec = make_rec(srp_pkg::KIND_ERROR, srp_pkg::ERR_EYE,
                                       '0, '0, '0, '0, '0, '0);
                        prs_phase = PRS_DONE;
                    end else begin
                        rec = make_rec(srp_pkg::KIND_HEADER, srp_pkg::ERR_NONE,
                                       '0, '0, '0, '0, '0, '0);
                        block_idx = '0;
                        ofs       = '0;
                        shift     = '0;
                        prs_phase = (blocks_total == 0) ? PRS_DONE : PRS_BLKHDR;
                    end
                end else begin
                    ofs = o + 8'd1;
                end
            end
            // block header: type, reserved, format, length, sensor count
            PRS_BLKHDR: begin
                shift = {shift[55:0], b};
                if (o < srp_pkg::BLKHDR_LAST) begin
                    ofs = o + 8'd1;
                end else begin
                    tag   = shift[63:32];
                    known = 1'b1;
                    case (tag)
                        srp_pkg::TAG_TEMP: btype = srp_pkg::BTYPE_TEMP;
                        srp_pkg::TAG_FREQ: btype = srp_pkg::BTYPE_FREQ;
                        srp_pkg::TAG_POWR: btype = srp_pkg::BTYPE_POWR;
                        default:           known = 1'b0;
                    endcase
                    if (!known) begin
                        got = 1'b1;
                        rec = make_rec(srp_pkg::KIND_ERROR, srp_pkg::ERR_BAD_TYPE,
                                       block_idx, '0, '0, '0, '0, '0);
                        prs_phase = PRS_DONE;
                    end else begin
                        rsize = (btype == srp_pkg::BTYPE_POWR) ? srp_pkg::POWR_SIZE
                                                               : srp_pkg::SMALL_SIZE;
                        stride_len     = (shift[15:8] < rsize) ? rsize : shift[15:8];
                        sensors_in_blk = shift[7:0];
                        sensor_idx     = '0;
                        ofs            = '0;
                        shift          = '0;
                        if (sensors_in_blk == 0) advance_block();
                        else prs_phase = PRS_SENSOR;
                    end
                end
            end
            // sensor records at the block stride
            PRS_SENSOR: begin
                if (btype == srp_pkg::BTYPE_POWR) begin
                    if (o < srp_pkg::POWR_SIZE) shift = {shift[55:0], b};
                    if (o == srp_pkg::POWR_TAG_END) begin
                        tag_latch = shift[31:0];
                        shift     = {48'd0, shift[47:32]};
                    end
                    if (o == srp_pkg::POWR_LAST) begin
                        got = 1'b1;
                        rec = make_rec(srp_pkg::KIND_POWR, srp_pkg::ERR_NONE,
                                       block_idx, sensor_idx, shift[63:48], shift[15:0],
                                       tag_latch, shift[47:16]);
                    end
                end else begin
                    if (o < srp_pkg::SMALL_SIZE) shift = {shift[55:0], b};
                    if (o == srp_pkg::SMALL_LAST) begin
                        got = 1'b1;
                        rec = make_rec((btype == srp_pkg::BTYPE_TEMP) ? srp_pkg::KIND_TEMP
                                                                      : srp_pkg::KIND_FREQ,
                                       srp_pkg::ERR_NONE, block_idx, sensor_idx,
                                       shift[31:16], shift[15:0], '0, '0);
                    end
                end
                if (int'(o) + 1 >= int'(stride_len)) begin
                    sensor_idx = sensor_idx + 8'd1;
                    ofs        = '0;
                    shift      = '0;
                    if (sensor_idx >= sensors_in_blk) advance_block();
                end else begin
                    ofs = o + 8'd1;
                end
            end
            default: ;
        endcase
    endtask

    // record that a directed row states outright
    function automatic srp_pkg::t_out_rec row_rec(input t_frame f, input logic [2:0] kind,
                                                  input logic [1:0] err);
        srp_pkg::t_out_rec r;
        r              = '0;
        r.rec_kind     = kind;
        r.error_code   = err;
        r.resp_seq     = f.seq;
        r.cmd_code     = f.cmd;
        r.ret_code     = f.status;
        r.ctrl_state   = f.state;
        return r;
    endfunction

    // queue one byte request
    task automatic push_byte(input logic [7:0] v, input logic first, input logic typed);
        t_stim_byte sb;
        sb.req.data_byte  = v;
        sb.req.first_byte = first;
        sb.typed          = typed;
        stim_q.push_back(sb);
    endtask

    // turn a frame description into byte requests
    task automatic add_frame(input t_frame f);
        logic [7:0] body [$];
        logic [7:0] v;
        logic       typed;
        int         size;
        int         stride_bytes;
        typed = (f.outcome != ROW_PREDICTED);
        if (f.lead_noise) repeat (3) push_byte(8'($urandom), 1'b0, typed);
        for (int k = 0; k <= int'(srp_pkg::HDR_LAST); k++) begin
            v = 8'($urandom);
            if (k == srp_pkg::OFS_SEQ) v = f.seq;
            if (k == srp_pkg::OFS_CMD) v = f.cmd;
            if (k == srp_pkg::OFS_STATUS) v = f.status;
            if (k == srp_pkg::OFS_STATE) v = f.state;
            if (k >= srp_pkg::OFS_EYE_LO && k <= srp_pkg::OFS_EYE_HI) begin
                v = EYE_TEXT[8 * (srp_pkg::OFS_EYE_HI - k) +: 8];
                if (int'(f.eye_bad) == k - srp_pkg::OFS_EYE_LO + 1) v = v ^ 8'h20;
            end
            if (k == srp_pkg::OFS_NBLOCKS) v = f.nblocks;
            body.push_back(v);
        end
        for (int j = 0; j < int'(f.nblk_emit); j++) begin
            for (int t = 3; t >= 0; t--) body.push_back(f.blk[j].tag[8 * t +: 8]);
            body.push_back(8'($urandom));
            body.push_back(8'($urandom));
            body.push_back(f.blk[j].len);
            body.push_back(f.blk[j].count);
            size = (f.blk[j].tag == srp_pkg::TAG_POWR) ? srp_pkg::POWR_SIZE
                                                       : srp_pkg::SMALL_SIZE;
            stride_bytes = (f.blk[j].len < size) ? size : f.blk[j].len;
            for (int s = 0; s < int'(f.blk[j].emit); s++) begin
                for (int i = 0; i < stride_bytes; i++) begin
                    case (f.fill)
                        FILL_ZERO: body.push_back(8'h00);
                        FILL_ONES: body.push_back(8'hFF);
                        default:   body.push_back(8'($urandom));
                    endcase
                end
            end
        end
        if (f.cut != 0) while (body.size() > f.cut) void'(body.pop_back());
        foreach (body[i]) push_byte(body[i], i == 0, typed);
        repeat (f.tail) push_byte(8'($urandom), 1'b0, typed);
        case (f.outcome)
            ROW_HEADER:
                typed_q.push_back(row_rec(f, srp_pkg::KIND_HEADER, srp_pkg::ERR_NONE));
            ROW_EYE_ERR:
                typed_q.push_back(row_rec(f, srp_pkg::KIND_ERROR, srp_pkg::ERR_EYE));
            ROW_TYPE_ERR: begin
                typed_q.push_back(row_rec(f, srp_pkg::KIND_HEADER, srp_pkg::ERR_NONE));
                typed_q.push_back(row_rec(f, srp_pkg::KIND_ERROR, srp_pkg::ERR_BAD_TYPE));
            end
            default: ;
        endcase
        frames_built++;
    endtask

    // mostly well-formed frames with random content, some broken ones
    function automatic t_frame random_frame();
        t_frame f;
        int     r;
        int     size;
        f            = '0;
        f.outcome    = ROW_PREDICTED;
        f.lead_noise = ($urandom_range(7) == 0);
        f.seq        = 8'($urandom);
        f.cmd        = 8'($urandom);
        f.status     = 8'($urandom);
        f.state      = 8'($urandom);
        f.eye_bad    = ($urandom_range(9) == 0) ? 3'($urandom_range(1, 6)) : 3'd0;
        f.nblk_emit  = 2'($urandom_range(0, 3));
        f.nblocks    = ($urandom_range(7) == 0) ? 8'($urandom) : 8'(f.nblk_emit);
        for (int j = 0; j < 3; j++) begin
            r = $urandom_range(19);
            if (r < 6) f.blk[j].tag = srp_pkg::TAG_TEMP;
            else if (r < 12) f.blk[j].tag = srp_pkg::TAG_FREQ;
            else if (r < 18) f.blk[j].tag = srp_pkg::TAG_POWR;
            else if (r == 18) f.blk[j].tag = $urandom;
            else f.blk[j].tag = srp_pkg::TAG_POWR ^ (32'd1 << $urandom_range(31));
            size = (f.blk[j].tag == srp_pkg::TAG_POWR) ? srp_pkg::POWR_SIZE
                                                       : srp_pkg::SMALL_SIZE;
            r = $urandom_range(9);
            if (r < 6) f.blk[j].len = 8'(size);
            else if (r < 9) f.blk[j].len = 8'($urandom_range(0, 16));
            else f.blk[j].len = 8'($urandom_range(17, 40));
            f.blk[j].count = 8'($urandom_range(0, 4));
            f.blk[j].emit  = ($urandom_range(9) == 0) ?
                             8'($urandom_range(0, f.blk[j].count)) : f.blk[j].count;
        end
        r = $urandom_range(19);
        if (r == 0) f.fill = FILL_ZERO;
        else if (r == 1) f.fill = FILL_ONES;
        else f.fill = FILL_RANDOM;
        f.cut  = ($urandom_range(11) == 0) ? 8'($urandom_range(1, 90)) : 8'd0;
        f.tail = ($urandom_range(3) == 0) ? 4'($urandom_range(1, 5)) : 4'd0;
        return f;
    endfunction

    // idle share of each side for the current stretch of the run
    function automatic int idle_pct(input bit sender);
        int third;
        third = (total_bytes == 0) ? 0 : bytes_done * 3 / total_bytes;
        if (third == 0) return sender ? 25 : 62;
        if (third == 1) return sender ? 62 : 25;
        return 0;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic compare_rec(input srp_pkg::t_out_rec want, input srp_pkg::t_out_rec got);
        check_field("rec_kind", want.rec_kind, got.rec_kind);
        check_field("error_code", want.error_code, got.error_code);
        check_field("resp_seq", want.resp_seq, got.resp_seq);
        check_field("cmd_code", want.cmd_code, got.cmd_code);
        check_field("ret_code", want.ret_code, got.ret_code);
        check_field("ctrl_state", want.ctrl_state, got.ctrl_state);
        check_field("block_index", want.block_index, got.block_index);
        check_field("sensor_index", want.sensor_index, got.sensor_index);
        check_field("sensor_ident", want.sensor_ident, got.sensor_ident);
        check_field("reading", want.reading, got.reading);
        check_field("update_count", want.update_count, got.update_count);
        check_field("energy_accum", want.energy_accum, got.energy_accum);
    endtask

    // byte sender: predict on acceptance, then offer the next request
    always @(posedge i_clk) begin : send_bytes
        bit                got;
        srp_pkg::t_out_rec rec;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                parse_byte(cur.req, got, rec);
                if (got) begin
                    if (cur.typed && typed_q.size() > 0) rec_q.push_back(typed_q.pop_front());
                    else rec_q.push_back(rec);
                end
                bytes_done++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (stim_q.size() > 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
                    cur = stim_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_in_req   <= cur.req;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // record receiver: compare, then pick the stall for the next cycle
    always @(posedge i_clk) begin : take_records
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (rec_q.size() == 0) begin
                    $error("record of kind %0d with nothing expected", o_out_rec.rec_kind);
                    fail_count++;
                end else begin
                    compare_rec(rec_q.pop_front(), o_out_rec);
                end
                recs_checked++;
                if (o_out_rec.rec_kind <= srp_pkg::KIND_ERROR) kind_seen[o_out_rec.rec_kind]++;
            end
            // one long hold-off halfway through so the parser backs up
            if (!pressure_done && bytes_done >= total_bytes / 2) begin
                hold_left     = 400;
                pressure_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < idle_pct(1'b0));
            end
        end
    end

    // run limit
    initial begin
        #1000000;
        $display("FAIL sensor_response_parser_core");
        $finish;
    end

    // main sequence
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_req    = '0;
        i_out_stall = 1'b0;
        clear_parse();

        // directed frames: one special case per row
        directed_rows = '{
            // noise after reset, zero blocks, trailing bytes
            '{ROW_HEADER, 1'b1, 8'hFF, 8'h00, 8'hFF, 8'h00, 3'd0, 8'd0, 2'd0,
              '{NO_BLK, NO_BLK, NO_BLK}, FILL_RANDOM, 8'd0, 4'd3},
            // eye catcher spoiled in its last character, blocks ignored
            '{ROW_EYE_ERR, 1'b0, 8'h00, 8'hFF, 8'h00, 8'hFF, 3'd6, 8'd1, 2'd1,
              '{'{srp_pkg::TAG_TEMP, 8'd4, 8'd1, 8'd1}, NO_BLK, NO_BLK},
              FILL_RANDOM, 8'd0, 4'd0},
            // eye catcher spoiled in its first character
            '{ROW_EYE_ERR, 1'b0, 8'h5A, 8'hA5, 8'h3C, 8'hC3, 3'd1, 8'd0, 2'd0,
              '{NO_BLK, NO_BLK, NO_BLK}, FILL_RANDOM, 8'd0, 4'd0},
            // near-miss type in the first block
            '{ROW_TYPE_ERR, 1'b0, 8'h12, 8'h34, 8'h56, 8'h78, 3'd0, 8'd2, 2'd2,
              '{'{srp_pkg::TAG_TEMP ^ 32'h3, 8'd4, 8'd2, 8'd2},
                '{srp_pkg::TAG_FREQ, 8'd4, 8'd1, 8'd1}, NO_BLK},
              FILL_RANDOM, 8'd0, 4'd2},
            // short temperature stride raised to the record size
            '{ROW_PREDICTED, 1'b0, 8'h01, 8'h02, 8'h03, 8'h04, 3'd0, 8'd1, 2'd1,
              '{'{srp_pkg::TAG_TEMP, 8'd0, 8'd3, 8'd3}, NO_BLK, NO_BLK},
              FILL_ZERO, 8'd0, 4'd0},
            // long frequency stride, short power stride, all-ones data
            '{ROW_PREDICTED, 1'b0, 8'h80, 8'h7F, 8'h01, 8'hFE, 3'd0, 8'd2, 2'd2,
              '{'{srp_pkg::TAG_FREQ, 8'd7, 8'd2, 8'd2},
                '{srp_pkg::TAG_POWR, 8'd5, 8'd2, 8'd2}, NO_BLK},
              FILL_ONES, 8'd0, 4'd0},
            // empty block followed by a long power stride
            '{ROW_PREDICTED, 1'b0, 8'h11, 8'h22, 8'h33, 8'h44, 3'd0, 8'd2, 2'd2,
              '{'{srp_pkg::TAG_TEMP, 8'd9, 8'd0, 8'd0},
                '{srp_pkg::TAG_POWR, 8'd14, 8'd2, 8'd2}, NO_BLK},
              FILL_RANDOM, 8'd0, 4'd0},
            // restart in the middle of a power record
            '{ROW_PREDICTED, 1'b0, 8'hA0, 8'hB0, 8'hC0, 8'hD0, 3'd0, 8'd1, 2'd1,
              '{'{srp_pkg::TAG_POWR, 8'd12, 8'd3, 8'd3}, NO_BLK, NO_BLK},
              FILL_RANDOM, 8'd70, 4'd0},
            // restart in the middle of the header
            '{ROW_PREDICTED, 1'b0, 8'h0F, 8'hF0, 8'h55, 8'hAA, 3'd0, 8'd1, 2'd1,
              '{'{srp_pkg::TAG_TEMP, 8'd4, 8'd1, 8'd1}, NO_BLK, NO_BLK},
              FILL_RANDOM, 8'd20, 4'd0},
            // unknown type in the second block
            '{ROW_PREDICTED, 1'b0, 8'h99, 8'h88, 8'h77, 8'h66, 3'd0, 8'd3, 2'd3,
              '{'{srp_pkg::TAG_FREQ, 8'd4, 8'd1, 8'd1}, '{32'hFFFF_FFFF, 8'd0, 8'd1, 8'd0},
                '{srp_pkg::TAG_TEMP, 8'd4, 8'd1, 8'd1}}, FILL_RANDOM, 8'd0, 4'd0},
            // largest block count, sensor count and stride, cut inside the first stride
            '{ROW_PREDICTED, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd0, 8'd255, 2'd1,
              '{'{srp_pkg::TAG_TEMP, 8'd255, 8'd255, 8'd1}, NO_BLK, NO_BLK},
              FILL_ONES, 8'd62, 4'd0},
            // exact power and frequency strides, short temperature stride, bytes after the last block
            '{ROW_PREDICTED, 1'b0, 8'h42, 8'h24, 8'h18, 8'h81, 3'd0, 8'd3, 2'd3,
              '{'{srp_pkg::TAG_POWR, 8'd12, 8'd1, 8'd1}, '{srp_pkg::TAG_FREQ, 8'd4, 8'd2, 8'd2},
                '{srp_pkg::TAG_TEMP, 8'd3, 8'd1, 8'd1}}, FILL_RANDOM, 8'd0, 4'd4},
            // header one byte short gives nothing
            '{ROW_NOTHING, 1'b0, 8'h10, 8'h20, 8'h30, 8'h40, 3'd0, 8'd0, 2'd0,
              '{NO_BLK, NO_BLK, NO_BLK}, FILL_RANDOM, 8'd44, 4'd0},
            // all-zero header fields and data
            '{ROW_PREDICTED, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 8'd1, 2'd1,
              '{'{srp_pkg::TAG_FREQ, 8'd4, 8'd1, 8'd1}, NO_BLK, NO_BLK},
              FILL_ZERO, 8'd0, 4'd0}
        };
        foreach (directed_rows[i]) add_frame(directed_rows[i]);

        // random frames up to the planned byte count
        while (stim_q.size() < 1150) add_frame(random_frame());
        total_bytes = stim_q.size();

        // reset
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every request to go in and every record to come out
        while (stim_q.size() != 0 || i_in_valid || rec_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (typed_q.size() != 0) begin
            $error("%0d directed records never matched", typed_q.size());
            fail_count++;
        end
        $display("sent %0d bytes in %0d frames, compared %0d records",
                 bytes_done, frames_built, recs_checked);
        $display("records: %0d header, %0d temp, %0d freq, %0d power, %0d error",
                 kind_seen[srp_pkg::KIND_HEADER], kind_seen[srp_pkg::KIND_TEMP],
                 kind_seen[srp_pkg::KIND_FREQ], kind_seen[srp_pkg::KIND_POWR],
                 kind_seen[srp_pkg::KIND_ERROR]);
        if (fail_count == 0) begin
            $display("PASS sensor_response_parser_core");
        end else begin
            $display("FAIL sensor_response_parser_core");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/srp_pkg.sv
hw/rtl/srp_parser.sv
hw/rtl/srp_out_stage.sv
hw/rtl/sensor_response_parser_core.sv
verif/sensor_response_parser_core_test.sv
